/* design/sms_pkg.sv */
package sms_pkg;

   // one stored record: key above tag, as kept in the record memories
   typedef struct packed {
      logic [31:0] key;
      logic [7:0]  tag;
   } record_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic wr_en;      // write one record memory
      logic wr_sel;     // 0 writes memory 0, 1 writes memory 1
      logic wr_load;    // write data comes from the request item
      logic pick_left;  // merge write takes the left head
      logic rd_sel;     // memory whose read data is used next cycle
      logic load_a;     // left head takes the read data
      logic load_b;     // right head takes the read data
      logic rsp_load;   // result register takes the read data
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic left_gt_right;  // left head key is greater than right head key
   } status_type;

endpackage

/* design/sms_datapath.sv */
module sms_datapath #(
   parameter int MAX_RECORDS = 1024,
   parameter int AW = 10
) (
   input  logic                 clock,
   input  sms_pkg::cmd_type     cmd,
   output sms_pkg::status_type  status,
   input  logic [AW-1:0]        wr_addr,
   input  logic [AW-1:0]        rd_addr,
   input  logic [31:0]          req_key,
   input  logic [7:0]           req_tag,
   output logic [31:0]          rsp_key,
   output logic [7:0]           rsp_tag
);
   import sms_pkg::*;

   record_type mem0 [MAX_RECORDS];
   record_type mem1 [MAX_RECORDS];
   record_type rdata0_ff;
   record_type rdata1_ff;
   logic       rd_sel_ff;
   record_type rdata;
   record_type head_a_ff;
   record_type head_b_ff;
   record_type rsp_rec_ff;
   record_type wr_data;

   // write data: a loaded item or the chosen merge head
   always_comb begin
      if (cmd.wr_load) begin
         wr_data = '{key: req_key, tag: req_tag};
      end else if (cmd.pick_left) begin
         wr_data = head_a_ff;
      end else begin
         wr_data = head_b_ff;
      end
   end

   // record memory 0, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en && !cmd.wr_sel) begin
         mem0[wr_addr] <= wr_data;
      end
      rdata0_ff <= mem0[rd_addr];
   end

   // record memory 1, the other half of the ping-pong pair
   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_sel) begin
         mem1[wr_addr] <= wr_data;
      end
      rdata1_ff <= mem1[rd_addr];
   end

   // read data select is registered, so it lines up with the registered read data
   always_ff @(posedge clock) begin
      rd_sel_ff <= cmd.rd_sel;
   end

   assign rdata = rd_sel_ff ? rdata1_ff : rdata0_ff;

   // merge heads and result register
   always_ff @(posedge clock) begin
      if (cmd.load_a) begin
         head_a_ff <= rdata;
      end
      if (cmd.load_b) begin
         head_b_ff <= rdata;
      end
      if (cmd.rsp_load) begin
         rsp_rec_ff <= rdata;
      end
   end

   // signed key compare of the two heads
   assign status.left_gt_right = $signed(head_a_ff.key) > $signed(head_b_ff.key);

   assign rsp_key = rsp_rec_ff.key;
   assign rsp_tag = rsp_rec_ff.tag;

endmodule

/* design/sms_controller.sv */
module sms_controller #(
   parameter int MAX_RECORDS = 1024,
   parameter int AW = 10,
   parameter int CW = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic                 req_final_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_last,
   output sms_pkg::cmd_type     cmd,
   input  sms_pkg::status_type  status,
   output logic [AW-1:0]        wr_addr,
   output logic [AW-1:0]        rd_addr
);
   import sms_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_RUN_START = 3'd1;
   localparam logic [2:0] ST_RD_A      = 3'd2;
   localparam logic [2:0] ST_RD_B      = 3'd3;
   localparam logic [2:0] ST_MERGE     = 3'd4;
   localparam logic [2:0] ST_FILL      = 3'd5;
   localparam logic [2:0] ST_FETCH     = 3'd6;

   localparam logic [CW-1:0] CAPACITY = CW'(MAX_RECORDS);
   localparam logic [CW-1:0] ONE      = CW'(1);

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic          sorted_ff, sorted_in;
   logic          res_sel_ff, res_sel_in;
   logic          src_ff, src_in;
   logic [CW-1:0] width_ff, width_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;
   logic [CW-1:0] k_ff, k_in;
   logic          fill_left_ff, fill_left_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          last_ff, last_in;

   logic          accept;
   logic [CW-1:0] count_eff;
   logic          room;
   logic [CW-1:0] count_new;
   logic [CW:0]   mid_sum;
   logic [CW:0]   hi_sum;
   logic [CW:0]   width_dbl;
   logic          take_left;
   logic [CW-1:0] a_next;
   logic [CW-1:0] b_next;
   logic [CW-1:0] k_next;
   logic [CW-1:0] rp_next;

   assign req_ready = (state_ff == ST_IDLE) && !(rsp_valid_ff && !rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = last_ff;

   // load bookkeeping: a load after the sort opens a new batch
   assign count_eff = sorted_ff ? '0 : count_ff;
   assign room      = count_eff != CAPACITY;
   assign count_new = room ? count_eff + ONE : count_eff;

   // run bounds, clipped to the record count
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, width_ff};
   assign hi_sum    = mid_sum + {1'b0, width_ff};
   assign width_dbl = {width_ff, 1'b0};

   // merge choice: left on ties keeps the sort stable
   assign take_left = (a_ff != mid_ff) && ((b_ff == hi_ff) || !status.left_gt_right);
   assign a_next    = a_ff + ONE;
   assign b_next    = b_ff + ONE;
   assign k_next    = k_ff + ONE;
   assign rp_next   = rp_ff + ONE;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      sorted_in    = sorted_ff;
      res_sel_in   = res_sel_ff;
      src_in       = src_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      fill_left_in = fill_left_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rd_sel   = src_ff;
      wr_addr      = '0;
      rd_addr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_mode) begin
               // load an item into memory 0
               cmd.wr_en   = room;
               cmd.wr_sel  = 1'b0;
               cmd.wr_load = 1'b1;
               wr_addr     = count_eff[AW-1:0];
               count_in    = count_new;
               rp_in       = '0;
               sorted_in   = 1'b0;
               if (req_final_load) begin
                  if (count_new <= ONE) begin
                     sorted_in  = 1'b1;
                     res_sel_in = 1'b0;
                  end else begin
                     width_in = ONE;
                     lo_in    = '0;
                     src_in   = 1'b0;
                     state_in = ST_RUN_START;
                  end
               end
            end else if (accept && req_mode) begin
               // fetch the next sorted record, if any is left
               if (sorted_ff && (rp_ff != count_ff)) begin
                  rd_addr    = rp_ff[AW-1:0];
                  cmd.rd_sel = res_sel_ff;
                  rp_in      = rp_next;
                  last_in    = rp_next == count_ff;
                  state_in   = ST_FETCH;
               end
            end
         end
         ST_RUN_START: begin
            rd_addr = lo_ff[AW-1:0];
            mid_in  = (mid_sum >= {1'b0, count_ff}) ? count_ff : mid_sum[CW-1:0];
            hi_in   = (hi_sum >= {1'b0, count_ff}) ? count_ff : hi_sum[CW-1:0];
            a_in    = lo_ff;
            k_in    = lo_ff;
            b_in    = (mid_sum >= {1'b0, count_ff}) ? count_ff : mid_sum[CW-1:0];
            state_in = ST_RD_A;
         end
         ST_RD_A: begin
            cmd.load_a = 1'b1;
            rd_addr    = mid_ff[AW-1:0];
            state_in   = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.load_b = 1'b1;
            state_in   = ST_MERGE;
         end
         ST_MERGE: begin
            // write one merged record into the other memory
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = ~src_ff;
            cmd.pick_left = take_left;
            wr_addr       = k_ff[AW-1:0];
            k_in          = k_next;
            fill_left_in  = take_left;
            if (take_left) begin
               a_in    = a_next;
               rd_addr = a_next[AW-1:0];
            end else begin
               b_in    = b_next;
               rd_addr = b_next[AW-1:0];
            end
            if (k_next != hi_ff) begin
               state_in = ST_FILL;
            end else if (hi_ff != count_ff) begin
               lo_in    = hi_ff;
               state_in = ST_RUN_START;
            end else begin
               // pass done: swap memories; double the run width, or finish when one run holds all records
               src_in = ~src_ff;
               if (width_dbl >= {1'b0, count_ff}) begin
                  sorted_in  = 1'b1;
                  res_sel_in = ~src_ff;
                  state_in   = ST_IDLE;
               end else begin
                  width_in = width_dbl[CW-1:0];
                  lo_in    = '0;
                  state_in = ST_RUN_START;
               end
            end
         end
         ST_FILL: begin
            cmd.load_a = fill_left_ff;
            cmd.load_b = !fill_left_ff;
            state_in   = ST_MERGE;
         end
         ST_FETCH: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rp_ff        <= '0;
         sorted_ff    <= 1'b0;
         res_sel_ff   <= 1'b0;
         src_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         sorted_ff    <= sorted_in;
         res_sel_ff   <= res_sel_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // run pointers and result flag
   always_ff @(posedge clock) begin
      width_ff     <= width_in;
      lo_ff        <= lo_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      k_ff         <= k_in;
      fill_left_ff <= fill_left_in;
      last_ff      <= last_in;
   end

endmodule

/* design/stable_merge_sort_records_core.sv */
// Stable merge sort of signed 32-bit keys with an 8-bit tag.
// Input channel req_*: req_mode 0 loads one record (req_key, req_tag) into
// the next free slot; req_final_load ends the batch and starts the sort.
// Loads beyond MAX_RECORDS are dropped. A load after a finished sort starts
// a new batch. req_mode 1 fetches the next sorted record; a fetch before the
// sort starts or after the last record is taken and gives no result.
// Result channel rsp_*: rsp_out_key, rsp_out_tag, and rsp_out_last on the
// final record of the batch.
// Loads are taken back to back while no result is stalled. A fetch reads
// the record memory, then ST_FETCH loads the result register and raises
// rsp_valid; no new item is taken before the fetch has left ST_FETCH. The
// sort is a bottom-up merge between two ping-pong record memories with one
// read port each: each run pair first reads both heads, then writes one
// merged record per merge step, and there are ceil(log2 N) passes for N
// records. req_ready stays low during the sort.
// Reset clears the record count, the read pointer and the sorted flag; the
// memories keep their contents. While the receiver stalls, the result holds
// and no new item is taken until it leaves.
module stable_merge_sort_records_core #(
   parameter int MAX_RECORDS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [31:0] req_key,
   input  logic [7:0]         req_tag,
   input  logic               req_final_load,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_key,
   output logic [7:0]         rsp_out_tag,
   output logic               rsp_out_last
);
   import sms_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);

   cmd_type       cmd;
   status_type    status;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rsp_key_bits;

   // sequencer: batch bookkeeping, run pointers, handshakes
   sms_controller #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW),
      .CW          (CW)
   ) u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_final_load (req_final_load),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_last       (rsp_out_last),
      .cmd            (cmd),
      .status         (status),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr)
   );

   // record memories, merge heads, compare and result register
   sms_datapath #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW)
   ) u_datapath (
      .clock   (clock),
      .cmd     (cmd),
      .status  (status),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .req_key (req_key),
      .req_tag (req_tag),
      .rsp_key (rsp_key_bits),
      .rsp_tag (rsp_out_tag)
   );

   assign rsp_out_key = $signed(rsp_key_bits);

endmodule

/* design/sms_checker.sv */
module sms_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_mode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_out_key,
   input logic [7:0]         rsp_out_tag,
   input logic               rsp_out_last
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_key)
         && $stable(rsp_out_tag) && $stable(rsp_out_last))
      else $error("stalled result changed");

   // nothing is shown right after reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

   // each result comes from an accepted fetch item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_mode, 2))
      else $error("result without a fetch item");

   // no item is taken while a result is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while result stalled");

   // a delivered result is not followed by another at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("results back to back");

endmodule

bind stable_merge_sort_records_core sms_checker u_sms_checker (.*);
